>>> hw/rtl/tcac_pkg.sv
// ----------------------------------------------------------------------------
// tcac_pkg
// Shared types and constants for the tile color average classifier.
// ----------------------------------------------------------------------------
package tcac_pkg;

  localparam int DEF_MAX_TILE_DIM     = 128;
  localparam int DEF_MAX_TILES_ACROSS = 64;
  localparam int DEF_MAX_TILES_DOWN   = 64;

  // configuration register indexes
  localparam logic [2:0] REG_TILE_DIM     = 3'd0;
  localparam logic [2:0] REG_TILES_ACROSS = 3'd1;
  localparam logic [2:0] REG_TILES_DOWN   = 3'd2;
  localparam logic [2:0] REG_MIN_COUNT    = 3'd3;
  localparam logic [2:0] REG_RANGE_LOW    = 3'd4;
  localparam logic [2:0] REG_RANGE_HIGH   = 3'd5;
  localparam logic [2:0] REG_REGION_PX    = 3'd6;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CMP_W      = 9;    // holds any parameter limit up to 256

  localparam int CH_W     = 8;
  localparam int IDX_W    = 6;
  localparam int POS_W    = 13;
  localparam int REGION_W = 14;
  localparam int MINC_W   = 15;

  localparam int IN_DATA_W  = 24;   // blue, green, red
  localparam int OUT_DATA_W = 96;   // 90 bits of fields, zero filled

  localparam logic [CFG_DATA_W-1:0] RST_TILE_DIM     = 24'd100;
  localparam logic [CFG_DATA_W-1:0] RST_TILES_ACROSS = 24'd1;
  localparam logic [CFG_DATA_W-1:0] RST_TILES_DOWN   = 24'd1;
  localparam logic [CFG_DATA_W-1:0] RST_MIN_COUNT    = 24'd6000;
  localparam logic [CFG_DATA_W-1:0] RST_RANGE_LOW    = 24'd3952653;
  localparam logic [CFG_DATA_W-1:0] RST_RANGE_HIGH   = 24'd6915648;
  localparam logic [CFG_DATA_W-1:0] RST_REGION_PX    = 24'd500;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/tcac_acc_mem.sv
// ----------------------------------------------------------------------------
// tcac_acc_mem
// Per-column accumulator memory: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcac_acc_mem import tcac_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_TILES_ACROSS,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 81
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tcac_div.sv
// ----------------------------------------------------------------------------
// tcac_div
// Restoring divider, one quotient bit per cycle, MSB first. The quotient
// must fit in Q_W bits.
// ----------------------------------------------------------------------------
module tcac_div import tcac_pkg::*; #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 15,
  parameter int Q_W   = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quo
);

  localparam int EXT_W = NUM_W + DEN_W + Q_W;
  localparam int K_W   = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [NUM_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [K_W-1:0]   k;
  logic [EXT_W-1:0] rem_ext;
  logic [EXT_W-1:0] sub_val;
  logic             fits;

  assign rem_ext = EXT_W'(rem);
  assign sub_val = EXT_W'(den_q) << k;
  assign fits    = rem_ext >= sub_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_q <= den;
      k     <= K_W'(Q_W - 1);
      quo   <= '0;
    end else if (busy) begin
      if (fits) begin
        rem    <= NUM_W'(rem_ext - sub_val);
        quo[k] <= 1'b1;
      end
      k <= k - K_W'(1);
    end
  end

endmodule

>>> hw/rtl/tile_color_average_classifier.sv
// ----------------------------------------------------------------------------
// tile_color_average_classifier
// Per-tile color averaging and range classification of a BGR pixel stream.
// ----------------------------------------------------------------------------
// A pixel is taken in the idle state, which reads the tile column's
// accumulators from the memory; the modify state writes them back. The last
// pixel of a tile adds a result phase run by serial dividers for the averages
// and region indexes, the latter as wide as a tile center (14 bits with
// default parameters); a result waiting in the output register holds the next
// one back. A pixel with start_of_frame, and reset, start a clearing pass over
// every accumulator memory entry during which no pixel is taken.
module tile_color_average_classifier import tcac_pkg::*; #(
  parameter int MAX_TILE_DIM     = DEF_MAX_TILE_DIM,
  parameter int MAX_TILES_ACROSS = DEF_MAX_TILES_ACROSS,
  parameter int MAX_TILES_DOWN   = DEF_MAX_TILES_DOWN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // blue, green, red
  input  logic                  s_tuser,   // start_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tile_col, tile_row, avg_blue, avg_green, avg_red, occupied, needs_water,
  // center_x, center_y, region_x, region_y, zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,   // last_tile
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_W = $clog2(MAX_TILE_DIM + 1);
  localparam int COL_W = (MAX_TILE_DIM > 1) ? $clog2(MAX_TILE_DIM) : 1;
  localparam int ACR_W = $clog2(MAX_TILES_ACROSS + 1);
  localparam int DWN_W = $clog2(MAX_TILES_DOWN + 1);
  localparam int TC_W  = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int TR_W  = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
  localparam int CNT_W = $clog2(MAX_TILE_DIM * MAX_TILE_DIM + 1);
  localparam int SUM_W = $clog2(MAX_TILE_DIM * MAX_TILE_DIM * 255 + 1);
  localparam int CXA_W = $clog2(MAX_TILES_ACROSS * MAX_TILE_DIM + 1);
  localparam int CYA_W = $clog2(MAX_TILES_DOWN * MAX_TILE_DIM + 1);
  localparam int ENT_W = CNT_W + 3 * SUM_W;

  // configuration registers
  logic [7:0]          tile_dim;
  logic [6:0]          tiles_across;
  logic [6:0]          tiles_down;
  logic [MINC_W-1:0]   min_count;
  logic [23:0]         range_low;
  logic [23:0]         range_high;
  logic [REGION_W-1:0] region_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_dim     <= 8'(RST_TILE_DIM);
      tiles_across <= 7'(RST_TILES_ACROSS);
      tiles_down   <= 7'(RST_TILES_DOWN);
      min_count    <= MINC_W'(RST_MIN_COUNT);
      range_low    <= RST_RANGE_LOW;
      range_high   <= RST_RANGE_HIGH;
      region_px    <= REGION_W'(RST_REGION_PX);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TILE_DIM:     tile_dim     <= cfg_data[7:0];
        REG_TILES_ACROSS: tiles_across <= cfg_data[6:0];
        REG_TILES_DOWN:   tiles_down   <= cfg_data[6:0];
        REG_MIN_COUNT:    min_count    <= cfg_data[MINC_W-1:0];
        REG_RANGE_LOW:    range_low    <= cfg_data;
        REG_RANGE_HIGH:   range_high   <= cfg_data;
        REG_REGION_PX:    region_px    <= cfg_data[REGION_W-1:0];
        default:          ;
      endcase
    end
  end

  // saturated geometry
  logic [CMP_W-1:0] td_x, ta_x, tn_x;
  logic [DIM_W-1:0] dim, dm1;
  logic [ACR_W-1:0] acr, am1;
  logic [DWN_W-1:0] dwn, nm1;
  logic [REGION_W-1:0] reg_div;

  always_comb begin
    td_x = CMP_W'(tile_dim);
    ta_x = CMP_W'(tiles_across);
    tn_x = CMP_W'(tiles_down);
    if (td_x == '0) dim = DIM_W'(1);
    else if (td_x > CMP_W'(MAX_TILE_DIM)) dim = DIM_W'(MAX_TILE_DIM);
    else dim = DIM_W'(td_x);
    if (ta_x == '0) acr = ACR_W'(1);
    else if (ta_x > CMP_W'(MAX_TILES_ACROSS)) acr = ACR_W'(MAX_TILES_ACROSS);
    else acr = ACR_W'(ta_x);
    if (tn_x == '0) dwn = DWN_W'(1);
    else if (tn_x > CMP_W'(MAX_TILES_DOWN)) dwn = DWN_W'(MAX_TILES_DOWN);
    else dwn = DWN_W'(tn_x);
    dm1 = dim - DIM_W'(1);
    am1 = acr - ACR_W'(1);
    nm1 = dwn - DWN_W'(1);
    reg_div = (region_px == '0) ? REGION_W'(1) : region_px;
  end

  // position of the next pixel
  logic [COL_W-1:0] col, row;
  logic [TC_W-1:0]  tcol;
  logic [TR_W-1:0]  trow;
  logic [COL_W-1:0] col_s, row_s, col_next, row_next;
  logic [TC_W-1:0]  tcol_s, tcol_next;
  logic [TR_W-1:0]  trow_s, trow_next;
  logic             sof, col_end, row_end, acr_end, dwn_end;

  always_comb begin
    sof    = s_tuser;
    col_s  = sof ? '0 : col;
    row_s  = sof ? '0 : row;
    tcol_s = sof ? '0 : tcol;
    trow_s = sof ? '0 : trow;
    if (DIM_W'(col_s) > dm1) col_s = COL_W'(dm1);
    if (DIM_W'(row_s) > dm1) row_s = COL_W'(dm1);
    if (ACR_W'(tcol_s) > am1) tcol_s = TC_W'(am1);
    if (DWN_W'(trow_s) > nm1) trow_s = TR_W'(nm1);
    col_end = DIM_W'(col_s) == dm1;
    row_end = DIM_W'(row_s) == dm1;
    acr_end = ACR_W'(tcol_s) == am1;
    dwn_end = DWN_W'(trow_s) == nm1;
    col_next  = col_s;
    row_next  = row_s;
    tcol_next = tcol_s;
    trow_next = trow_s;
    if (col_end) begin
      col_next = '0;
      if (acr_end) begin
        tcol_next = '0;
        if (row_end) begin
          row_next  = '0;
          trow_next = dwn_end ? '0 : trow_s + TR_W'(1);
        end else begin
          row_next = row_s + COL_W'(1);
        end
      end else begin
        tcol_next = tcol_s + TC_W'(1);
      end
    end else begin
      col_next = col_s + COL_W'(1);
    end
  end

  // control
  state_t state, state_next;
  logic [TC_W-1:0] clr_idx;
  logic            clr_last;
  logic            pix_pend;
  logic            accept;
  logic            div_busy;
  logic            out_free;
  logic            mem_we;
  logic [TC_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, mem_rdata;
  logic            div_start;

  // latched pixel
  logic [CH_W-1:0] px_b, px_g, px_r;
  logic            px_use;
  logic [TC_W-1:0] px_tc;
  logic [TR_W-1:0] px_tr;
  logic            px_end, px_last;

  assign clr_last = clr_idx == TC_W'(MAX_TILES_ACROSS - 1);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = pix_pend ? ST_READ : ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = sof ? ST_CLEAR : ST_MOD;
      ST_READ:  state_next = ST_MOD;
      ST_MOD:   state_next = px_end ? ST_DIV : ST_IDLE;
      ST_DIV:   if (!div_busy) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // accumulate
  logic [SUM_W-1:0] sum_b, sum_g, sum_r;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    {cnt, sum_r, sum_g, sum_b} = mem_rdata;
    if (px_use) begin
      sum_b = sum_b + SUM_W'(px_b);
      sum_g = sum_g + SUM_W'(px_g);
      sum_r = sum_r + SUM_W'(px_r);
      cnt   = cnt + CNT_W'(1);
    end
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = px_tc;
    mem_wdata = '0;
    mem_raddr = px_tc;
    div_start = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
      end
      ST_IDLE: begin
        s_tready  = 1'b1;
        mem_raddr = tcol_s;
      end
      ST_MOD: begin
        mem_we    = 1'b1;
        mem_wdata = px_end ? '0 : {cnt, sum_r, sum_g, sum_b};
        div_start = px_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      pix_pend <= 1'b0;
      col      <= '0;
      row      <= '0;
      tcol     <= '0;
      trow     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_last ? '0 : clr_idx + TC_W'(1);
        if (clr_last) pix_pend <= 1'b0;
      end
      if (accept) begin
        pix_pend <= sof;
        col      <= col_next;
        row      <= row_next;
        tcol     <= tcol_next;
        trow     <= trow_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_b    <= s_tdata[7:0];
      px_g    <= s_tdata[15:8];
      px_r    <= s_tdata[23:16];
      px_use  <= (s_tdata != '0) && (s_tdata != '1);
      px_tc   <= tcol_s;
      px_tr   <= trow_s;
      px_end  <= col_end && row_end;
      px_last <= acr_end && dwn_end;
    end
  end

  tcac_acc_mem #(
    .DEPTH  (MAX_TILES_ACROSS),
    .ADDR_W (TC_W),
    .DATA_W (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // tile result
  logic [CXA_W-1:0] cx;
  logic [CYA_W-1:0] cy;
  logic [CXA_W-1:0] res_cx;
  logic [CYA_W-1:0] res_cy;
  logic             res_use;
  logic [TC_W-1:0]  res_tc;
  logic [TR_W-1:0]  res_tr;
  logic             res_last;
  logic [CH_W-1:0]  q_b, q_g, q_r;
  logic [CXA_W-1:0] q_x;
  logic [CYA_W-1:0] q_y;
  logic [4:0]       busy_v;

  assign cx = CXA_W'(px_tc) * CXA_W'(dim) + CXA_W'(dim >> 1);
  assign cy = CYA_W'(px_tr) * CYA_W'(dim) + CYA_W'(dim >> 1);
  assign div_busy = |busy_v;

  always_ff @(posedge clk) begin
    if (div_start) begin
      res_cx   <= cx;
      res_cy   <= cy;
      res_use  <= (32'(cnt) > 32'(min_count)) && (cnt != '0);
      res_tc   <= px_tc;
      res_tr   <= px_tr;
      res_last <= px_last;
    end
  end

  tcac_div #(.NUM_W(SUM_W), .DEN_W(CNT_W), .Q_W(CH_W)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_b), .den(cnt),
    .busy(busy_v[0]), .quo(q_b)
  );
  tcac_div #(.NUM_W(SUM_W), .DEN_W(CNT_W), .Q_W(CH_W)) u_div_g (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_g), .den(cnt),
    .busy(busy_v[1]), .quo(q_g)
  );
  tcac_div #(.NUM_W(SUM_W), .DEN_W(CNT_W), .Q_W(CH_W)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_r), .den(cnt),
    .busy(busy_v[2]), .quo(q_r)
  );
  tcac_div #(.NUM_W(CXA_W), .DEN_W(REGION_W), .Q_W(CXA_W)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .num(cx), .den(reg_div),
    .busy(busy_v[3]), .quo(q_x)
  );
  tcac_div #(.NUM_W(CYA_W), .DEN_W(REGION_W), .Q_W(CYA_W)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .num(cy), .den(reg_div),
    .busy(busy_v[4]), .quo(q_y)
  );

  logic [CH_W-1:0] avg_b, avg_g, avg_r;
  logic            occ, in_rng;

  always_comb begin
    avg_b  = res_use ? q_b : '0;
    avg_g  = res_use ? q_g : '0;
    avg_r  = res_use ? q_r : '0;
    occ    = (avg_b | avg_g | avg_r) != '0;
    in_rng = (avg_b >= range_low[7:0])   && (avg_b <= range_high[7:0]) &&
             (avg_g >= range_low[15:8])  && (avg_g <= range_high[15:8]) &&
             (avg_r >= range_low[23:16]) && (avg_r <= range_high[23:16]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {6'b0,
                  POS_W'(q_y), POS_W'(q_x), POS_W'(res_cy), POS_W'(res_cx),
                  occ && !in_rng, occ, avg_r, avg_g, avg_b,
                  IDX_W'(res_tr), IDX_W'(res_tc)};
      m_tlast <= res_last;
    end
  end

endmodule

>>> hw/rtl/tcac_checker.sv
// ----------------------------------------------------------------------------
// tcac_checker
// Port-level checks for the tile color average classifier.
// ----------------------------------------------------------------------------
module tcac_checker import tcac_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // one pixel at a time: a read-modify-write follows every accepted word
  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("pixel accepted back to back");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // an unoccupied tile has a black average and never needs water
  a_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[36] |-> !m_tdata[37] && m_tdata[35:12] == '0)
    else $error("unoccupied tile with color or water flag");

endmodule

bind tile_color_average_classifier tcac_checker u_tcac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile color average classifier. A short table of
// single-pixel tiles pins down black and white rejection, range edges and the
// flags; random phases then sweep tile geometry, thresholds and color ranges
// under varied stream idling, each tile result checked against a local model.
// ----------------------------------------------------------------------------
module tb_top;
  import tcac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  col;
    logic [5:0]  row;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        occ;
    logic        water;
    logic [12:0] cx;
    logic [12:0] cy;
    logic [12:0] rx;
    logic [12:0] ry;
    logic        last;
  } tile_res_t;

  typedef struct {
    bit         sof;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    bit         typed;
    logic [7:0] e_blue;
    logic [7:0] e_green;
    logic [7:0] e_red;
    bit         e_occ;
    bit         e_water;
  } pixel_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // blue, green, red
  logic                  s_tuser = 1'b0; // start_of_frame
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tile_color_average_classifier DUT (.*);

  // local mirror of the block
  int unsigned cfg_dim, cfg_across, cfg_down, cfg_minc, cfg_lo, cfg_hi, cfg_region;
  int unsigned sum_b [64];
  int unsigned sum_g [64];
  int unsigned sum_r [64];
  int unsigned px_cnt [64];
  int unsigned col_in, tile_c, row_in, tile_r;

  tile_res_t   pending_tiles [$];
  int          errors = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit in_band(int unsigned v, int sh);
    return v >= ((cfg_lo >> sh) & 8'hFF) && v <= ((cfg_hi >> sh) & 8'hFF);
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < 64; i++) begin
      sum_b[i] = 0; sum_g[i] = 0; sum_r[i] = 0; px_cnt[i] = 0;
    end
  endfunction

  // Accumulate one pixel; returns 1 when it closes a tile.
  function automatic bit tile_average(input bit sof, input logic [7:0] b, g, r,
                                      output tile_res_t t);
    int unsigned dim, across, down, reg_px, cnt, ab, ag, ar, cx, cy;
    bit occ, in_rng, done;
    dim    = clamp(cfg_dim, 1, DEF_MAX_TILE_DIM);
    across = clamp(cfg_across, 1, DEF_MAX_TILES_ACROSS);
    down   = clamp(cfg_down, 1, DEF_MAX_TILES_DOWN);
    reg_px = (cfg_region == 0) ? 1 : cfg_region;
    done   = 1'b0;
    t      = '{default: '0};
    if (sof) begin
      clear_sums();
      col_in = 0; tile_c = 0; row_in = 0; tile_r = 0;
    end
    // shrunk geometry: pin to the last position
    if (col_in > dim - 1) col_in = dim - 1;
    if (row_in > dim - 1) row_in = dim - 1;
    if (tile_c > across - 1) tile_c = across - 1;
    if (tile_r > down - 1) tile_r = down - 1;
    if (!(b == 0 && g == 0 && r == 0) && !(b == 255 && g == 255 && r == 255)) begin
      sum_b[tile_c] += b; sum_g[tile_c] += g; sum_r[tile_c] += r;
      px_cnt[tile_c] += 1;
    end
    if (col_in == dim - 1 && row_in == dim - 1) begin
      cnt = px_cnt[tile_c];
      ab = 0; ag = 0; ar = 0;
      if (cnt > cfg_minc && cnt != 0) begin
        ab = sum_b[tile_c] / cnt; ag = sum_g[tile_c] / cnt; ar = sum_r[tile_c] / cnt;
      end
      occ    = (ab | ag | ar) != 0;
      in_rng = in_band(ab, 0) && in_band(ag, 8) && in_band(ar, 16);
      cx = tile_c * dim + dim / 2;
      cy = tile_r * dim + dim / 2;
      t.col = tile_c[5:0]; t.row = tile_r[5:0];
      t.blue = ab[7:0]; t.green = ag[7:0]; t.red = ar[7:0];
      t.occ = occ; t.water = occ && !in_rng;
      t.cx = cx[12:0]; t.cy = cy[12:0];
      t.rx = 13'(cx / reg_px); t.ry = 13'(cy / reg_px);
      t.last = (tile_c == across - 1 && tile_r == down - 1);
      sum_b[tile_c] = 0; sum_g[tile_c] = 0; sum_r[tile_c] = 0; px_cnt[tile_c] = 0;
      done = 1'b1;
    end
    // advance
    if (col_in == dim - 1) begin
      col_in = 0;
      if (tile_c == across - 1) begin
        tile_c = 0;
        if (row_in == dim - 1) begin
          row_in = 0;
          tile_r = (tile_r == down - 1) ? 0 : tile_r + 1;
        end else begin
          row_in++;
        end
      end else begin
        tile_c++;
      end
    end else begin
      col_in++;
    end
    return done;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  tile_res_t got_tile, want_tile;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_tile.col   = m_tdata[5:0];
      got_tile.row   = m_tdata[11:6];
      got_tile.blue  = m_tdata[19:12];
      got_tile.green = m_tdata[27:20];
      got_tile.red   = m_tdata[35:28];
      got_tile.occ   = m_tdata[36];
      got_tile.water = m_tdata[37];
      got_tile.cx    = m_tdata[50:38];
      got_tile.cy    = m_tdata[63:51];
      got_tile.rx    = m_tdata[76:64];
      got_tile.ry    = m_tdata[89:77];
      got_tile.last  = m_tlast;
      if (pending_tiles.size() == 0) begin
        report_mismatch("unexpected tile col", got_tile.col, -1);
      end else begin
        want_tile = pending_tiles.pop_front();
        if (got_tile.col != want_tile.col) report_mismatch("tile_col", got_tile.col, want_tile.col);
        if (got_tile.row != want_tile.row) report_mismatch("tile_row", got_tile.row, want_tile.row);
        if (got_tile.blue != want_tile.blue)
          report_mismatch("avg_blue", got_tile.blue, want_tile.blue);
        if (got_tile.green != want_tile.green)
          report_mismatch("avg_green", got_tile.green, want_tile.green);
        if (got_tile.red != want_tile.red) report_mismatch("avg_red", got_tile.red, want_tile.red);
        if (got_tile.occ != want_tile.occ) report_mismatch("occupied", got_tile.occ, want_tile.occ);
        if (got_tile.water != want_tile.water)
          report_mismatch("needs_water", got_tile.water, want_tile.water);
        if (got_tile.cx != want_tile.cx) report_mismatch("center_x", got_tile.cx, want_tile.cx);
        if (got_tile.cy != want_tile.cy) report_mismatch("center_y", got_tile.cy, want_tile.cy);
        if (got_tile.rx != want_tile.rx) report_mismatch("region_x", got_tile.rx, want_tile.rx);
        if (got_tile.ry != want_tile.ry) report_mismatch("region_y", got_tile.ry, want_tile.ry);
        if (got_tile.last != want_tile.last)
          report_mismatch("last_tile", got_tile.last, want_tile.last);
      end
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_TILE_DIM:     cfg_dim    = 32'(val & 24'hFF);
      REG_TILES_ACROSS: cfg_across = 32'(val & 24'h7F);
      REG_TILES_DOWN:   cfg_down   = 32'(val & 24'h7F);
      REG_MIN_COUNT:    cfg_minc   = 32'(val & 24'h7FFF);
      REG_RANGE_LOW:    cfg_lo     = 32'(val);
      REG_RANGE_HIGH:   cfg_hi     = 32'(val);
      REG_REGION_PX:    cfg_region = 32'(val & 24'h3FFF);
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned dim, across, down, minc, lo, hi, region);
    write_reg(REG_TILE_DIM, 24'(dim));
    write_reg(REG_TILES_ACROSS, 24'(across));
    write_reg(REG_TILES_DOWN, 24'(down));
    write_reg(REG_MIN_COUNT, 24'(minc));
    write_reg(REG_RANGE_LOW, 24'(lo));
    write_reg(REG_RANGE_HIGH, 24'(hi));
    write_reg(REG_REGION_PX, 24'(region));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_tiles.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Offer one word and hold it until taken; returns the expectation, if any.
  task automatic send_pixel(bit sof, logic [7:0] b, g, r,
                            output bit has_tile, output tile_res_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= sof;
    s_tdata  <= {r, g, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    has_tile = tile_average(sof, b, g, r, t);
  endtask

  task automatic send_and_track(bit sof, logic [7:0] b, g, r);
    bit has_tile;
    tile_res_t t;
    send_pixel(sof, b, g, r, has_tile, t);
    if (has_tile) pending_tiles = {pending_tiles, t};
  endtask

  function automatic logic [23:0] random_pixel();
    case ($urandom_range(7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {8'($urandom_range(16, 64)), 8'($urandom_range(32, 134)),
                 8'($urandom_range(13, 64))};
      default: return 24'($urandom);
    endcase
  endfunction

  // single-pixel tiles: range is blue 30..60, green 20..50, red 10..40 (hex)
  pixel_row_t directed_rows [16] = '{
    '{1, 8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00, 0, 0},
    '{0, 8'hFF, 8'hFF, 8'hFF, 1, 8'h00, 8'h00, 8'h00, 0, 0},
    '{0, 8'hFF, 8'hFF, 8'hFE, 1, 8'hFF, 8'hFF, 8'hFE, 1, 1},
    '{0, 8'h01, 8'h00, 8'h00, 1, 8'h01, 8'h00, 8'h00, 1, 1},
    '{0, 8'h30, 8'h20, 8'h10, 1, 8'h30, 8'h20, 8'h10, 1, 0},
    '{0, 8'h60, 8'h50, 8'h40, 1, 8'h60, 8'h50, 8'h40, 1, 0},
    '{0, 8'h61, 8'h50, 8'h40, 1, 8'h61, 8'h50, 8'h40, 1, 1},
    '{0, 8'h2F, 8'h20, 8'h10, 1, 8'h2F, 8'h20, 8'h10, 1, 1},
    '{0, 8'h40, 8'h1F, 8'h20, 1, 8'h40, 8'h1F, 8'h20, 1, 1},
    '{0, 8'h40, 8'h51, 8'h20, 1, 8'h40, 8'h51, 8'h20, 1, 1},
    '{0, 8'h40, 8'h30, 8'h0F, 1, 8'h40, 8'h30, 8'h0F, 1, 1},
    '{0, 8'h40, 8'h30, 8'h41, 1, 8'h40, 8'h30, 8'h41, 1, 1},
    '{1, 8'hAA, 8'h55, 8'hAA, 0, 8'h00, 8'h00, 8'h00, 0, 0},
    '{0, 8'h55, 8'hAA, 8'h55, 0, 8'h00, 8'h00, 8'h00, 0, 0},
    '{1, 8'h00, 8'h00, 8'hFF, 0, 8'h00, 8'h00, 8'h00, 0, 0},
    '{0, 8'hFF, 8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 0, 0}
  };

  initial begin
    int unsigned dims [8] = '{1, 2, 3, 4, 2, 8, 0, 5};
    int unsigned dim, across, down, minc, n_px, area;
    bit has_tile;
    tile_res_t t;
    logic [23:0] px;
    int phase;

    cfg_dim = 32'(RST_TILE_DIM); cfg_across = 32'(RST_TILES_ACROSS);
    cfg_down = 32'(RST_TILES_DOWN); cfg_minc = 32'(RST_MIN_COUNT);
    cfg_lo = 32'(RST_RANGE_LOW); cfg_hi = 32'(RST_RANGE_HIGH);
    cfg_region = 32'(RST_REGION_PX);
    clear_sums();
    col_in = 0; tile_c = 0; row_in = 0; tile_r = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (120) @(posedge clk);

    // directed: every pixel is a tile, center 0 and region 0 throughout
    write_all(1, 1, 1, 0, 24'h102030, 24'h405060, 1);
    hold_req++;   // long receiver hold-off while the table keeps offering words
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].sof, directed_rows[i].blue, directed_rows[i].green,
                 directed_rows[i].red, has_tile, t);
      if (directed_rows[i].typed) begin
        t.blue = directed_rows[i].e_blue; t.green = directed_rows[i].e_green;
        t.red = directed_rows[i].e_red; t.occ = directed_rows[i].e_occ;
        t.water = directed_rows[i].e_water;
      end
      if (has_tile) pending_tiles = {pending_tiles, t};
    end
    s_tvalid <= 1'b0;
    drain();

    phase = 0;
    while (items_sent < 750 && phase < 60) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (phase == 3) begin
        // oversized registers saturate
        write_all(255, 0, 127, 16384, 24'($urandom), 24'($urandom), 16383);
        n_px = $urandom_range(40, 120);
      end else begin
        dim    = dims[$urandom_range(7)];
        across = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 127 : 64) : $urandom_range(0, 4);
        down   = ($urandom_range(5) == 0) ? 127 : $urandom_range(0, 3);
        area   = (dim == 0) ? 1 : dim * dim;
        case ($urandom_range(4))
          0: minc = 0;
          1: minc = area - 1;
          2: minc = area;
          3: minc = 32767;
          default: minc = $urandom_range(0, area);
        endcase
        write_all(dim, across, down, minc,
                  ($urandom_range(3) == 0) ? 24'($urandom) : 24'h0D2030,
                  ($urandom_range(3) == 0) ? 24'($urandom) : 24'hB0C0A0,
                  ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 16383));
        n_px = $urandom_range(40, 120);
      end
      for (int i = 0; i < n_px; i++) begin
        px = random_pixel();
        send_and_track((i == 0 && $urandom_range(1)) || $urandom_range(199) == 0,
                       px[7:0], px[15:8], px[23:16]);
        if (i == n_px / 2 && phase % 5 == 1) begin
          // pause the sender until the block has delivered everything
          s_tvalid <= 1'b0;
          while (pending_tiles.size() > 0) @(posedge clk);
        end
      end
      s_tvalid <= 1'b0;
      drain();
      phase++;
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tcac_pkg.sv
hw/rtl/tcac_acc_mem.sv
hw/rtl/tcac_div.sv
hw/rtl/tile_color_average_classifier.sv
hw/rtl/tcac_checker.sv
bench/tb_top.sv
